// File: hdl/xle_pkg.sv
// ----------------------------------------------------------------------------
// xle_pkg
// Shared types and constants of the cross-correlation lag estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package xle_pkg;

  // Sample and register widths are fixed by the interface.
  localparam int SAMPLE_W  = 24;
  localparam int WL_W      = 15;
  localparam int ML_W      = 13;
  localparam int LAG_OUT_W = 12;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [WL_W-1:0] WL_RESET = 15'd14400;
  localparam logic [ML_W-1:0] ML_RESET = 13'd3840;

  // Smallest integer energy product whose real square root exceeds 1e-12 for
  // Q1.23 samples.
  localparam int DENOM_MIN = 4952;

  // Register select bit of paddr.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_MAX_LAG       = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_EIN,
    S_EIN_WAIT,
    S_LAG_START,
    S_LAG_RUN,
    S_LAG_WAIT,
    S_MUL_DEN,
    S_MUL_SQ,
    S_DECIDE,
    S_MUL_X,
    S_MUL_Y,
    S_NEXT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    DST_EIN,
    DST_P,
    DST_E
  } dest_e;

  typedef enum logic [1:0] {
    MS_DEN,
    MS_SQ,
    MS_X,
    MS_Y
  } mul_sel_e;

endpackage

`default_nettype wire

// File: hdl/xle_ram.sv
// ----------------------------------------------------------------------------
// xle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module xle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/xcorr_lag_estimator_core.sv
// ----------------------------------------------------------------------------
// xcorr_lag_estimator_core
// Finds the lag of greatest normalised cross-correlation between a loaded
// reference signal and a recorded signal.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle: busy stays low and a pair is taken on
// every cycle with start high. The word marked last_pair starts the search,
// and busy stays high until the single result has been shown on best_lag_o
// for one cycle with done_o high; the receiver cannot stall it. The search
// runs an energy pass over the window and then, for each lag, a correlation
// pass and the exact comparison with the best lag so far. One shared 24x24
// multiplier runs the energy pass and then two products per sample and lag,
// and one shared shift-and-add unit with an EW-bit multiplier (61 bits by
// default) forms the exact comparisons, one multiplier bit per cycle. A
// window or lag count of zero goes from S_PREP straight to S_DONE. The stores
// need no clearing after reset, as samples beyond the fill count read as zero.
`default_nettype none

module xcorr_lag_estimator_core #(
  parameter int MAX_WINDOW = 16384,
  parameter int MAX_LAG    = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [xle_pkg::SAMPLE_W-1:0] reference_sample_i,
  input  wire logic signed [xle_pkg::SAMPLE_W-1:0] recorded_sample_i,
  input  wire logic                                last_pair_i,
  output logic                                     done_o,
  output logic [xle_pkg::LAG_OUT_W-1:0]            best_lag_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [xle_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [xle_pkg::DATA_W-1:0]          pwdata,
  output logic [xle_pkg::DATA_W-1:0]               prdata,
  output logic                                     pready
);

  localparam int SW        = xle_pkg::SAMPLE_W;
  localparam int REC_DEPTH = MAX_WINDOW + MAX_LAG;
  localparam int IW        = $clog2(MAX_WINDOW);
  localparam int RW        = $clog2(REC_DEPTH);
  localparam int CW        = $clog2(REC_DEPTH + 1);
  localparam int WLW       = $clog2(MAX_WINDOW + 1);
  localparam int LW        = $clog2(MAX_LAG);
  localparam int NLW       = $clog2(MAX_LAG + 1);
  localparam int EW        = 2 * SW - 2 + $clog2(MAX_WINDOW + 1);
  localparam int PW        = EW + 1;
  localparam int MW        = 3 * EW;
  localparam int MCW       = $clog2(EW + 1);

  // Control state.
  xle_pkg::state_e             state_q, state_d;
  logic [xle_pkg::WL_W-1:0]    wl_q;
  logic [xle_pkg::ML_W-1:0]    ml_q;
  logic [CW-1:0]               cnt_q;
  logic [WLW-1:0]              w_q, w_d;
  logic [NLW-1:0]              nlag_q, nlag_d;
  logic [IW-1:0]               i_q;
  logic                        phase_q;
  logic [LW-1:0]               lag_q;
  logic [LW-1:0]               best_lag_q;
  logic                        have_q;
  logic                        s1_v_q, s2_v_q;
  logic [MCW-1:0]              mcnt_q;

  // Datapath.
  xle_pkg::dest_e              s1_dest_q, s2_dest_q;
  logic                        s1_mref_q, s1_mrec_q;
  logic signed [2*SW-1:0]      s2_prod_q;
  logic signed [PW-1:0]        ein_q, p_q, e_q, bp_q;
  logic [EW-1:0]               be_q;
  logic [2*EW-1:0]             den_q, sq_q, bsq_q;
  logic                        valid_q;
  logic [MW-1:0]               x_q;
  logic [2*EW-1:0]             ma_q;
  logic [MW-1:0]               mr_q;

  // Combinational control.
  logic                        iss_v;
  xle_pkg::dest_e              iss_dest;
  logic                        mul_load;
  xle_pkg::mul_sel_e           mul_sel;
  logic                        upd;
  logic                        accept;
  logic                        last_i;
  logic                        last_lag;
  logic                        pipe_empty;
  logic                        mul_done;
  logic                        den_ok;

  logic signed [SW-1:0]        ref_rdata, rec_rdata;
  logic [RW-1:0]               rec_raddr;
  logic                        ref_we, rec_we;
  logic signed [SW-1:0]        op_a, op_b;
  logic signed [PW-1:0]        p_eff, p_neg;
  logic [EW-1:0]               e_eff, p_mag;
  logic [1:0]                  rank_a, rank_b;
  logic [2*EW-1:0]             mul_a;
  logic [EW-1:0]               mul_b;
  logic [2*EW:0]               m_sum;
  logic                        gt;

  assign accept     = start && !busy;
  assign pready     = 1'b1;
  assign last_i     = (WLW'(i_q) + WLW'(1)) == w_q;
  assign last_lag   = (NLW'(lag_q) + NLW'(1)) == nlag_q;
  assign pipe_empty = !s1_v_q && !s2_v_q;
  assign mul_done   = mcnt_q == '0;
  assign den_ok     = mr_q[2*EW-1:0] >= (2*EW)'(xle_pkg::DENOM_MIN);
  assign best_lag_o = xle_pkg::LAG_OUT_W'(best_lag_q);

  assign prdata = (paddr[2] == xle_pkg::REG_MAX_LAG) ? xle_pkg::DATA_W'(ml_q)
                                                     : xle_pkg::DATA_W'(wl_q);

  // Register limits saturate at the store sizes.
  always_comb begin
    if (32'(wl_q) > MAX_WINDOW) begin
      w_d = WLW'(MAX_WINDOW);
    end else begin
      w_d = WLW'(wl_q);
    end
    if (32'(ml_q) > MAX_LAG) begin
      nlag_d = NLW'(MAX_LAG);
    end else begin
      nlag_d = NLW'(ml_q);
    end
  end

  // Sample stores.
  assign ref_we    = accept && (32'(cnt_q) < MAX_WINDOW);
  assign rec_we    = accept && (32'(cnt_q) < REC_DEPTH);
  assign rec_raddr = RW'(i_q) + RW'(lag_q);

  xle_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WINDOW)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (reference_sample_i),
    .raddr_i (i_q),
    .rdata_o (ref_rdata)
  );

  xle_ram #(
    .WIDTH (SW),
    .DEPTH (REC_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (cnt_q[RW-1:0]),
    .wdata_i (recorded_sample_i),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  // Invalid lags count as a zero correlation over a unit energy.
  assign p_eff = valid_q ? p_q : '0;
  assign e_eff = valid_q ? e_q[EW-1:0] : EW'(1);
  assign p_neg = -p_q;
  assign p_mag = p_q[PW-1] ? p_neg[EW-1:0] : p_q[EW-1:0];

  // Sign rank: negative 0, zero 1, positive 2.
  always_comb begin
    if (p_eff == '0) begin
      rank_a = 2'd1;
    end else if (p_eff[PW-1]) begin
      rank_a = 2'd0;
    end else begin
      rank_a = 2'd2;
    end
    if (bp_q == '0) begin
      rank_b = 2'd1;
    end else if (bp_q[PW-1]) begin
      rank_b = 2'd0;
    end else begin
      rank_b = 2'd2;
    end
  end

  assign gt = (rank_a == 2'd2) ? (x_q > mr_q) : (x_q < mr_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      xle_pkg::S_IDLE: begin
        if (accept && last_pair_i) begin
          state_d = xle_pkg::S_PREP;
        end
      end
      xle_pkg::S_PREP: begin
        if (w_d == '0 || nlag_d == '0) begin
          state_d = xle_pkg::S_DONE;
        end else begin
          state_d = xle_pkg::S_EIN;
        end
      end
      xle_pkg::S_EIN: begin
        if (last_i) begin
          state_d = xle_pkg::S_EIN_WAIT;
        end
      end
      xle_pkg::S_EIN_WAIT: begin
        if (pipe_empty) begin
          state_d = xle_pkg::S_LAG_START;
        end
      end
      xle_pkg::S_LAG_START: begin
        state_d = xle_pkg::S_LAG_RUN;
      end
      xle_pkg::S_LAG_RUN: begin
        if (phase_q && last_i) begin
          state_d = xle_pkg::S_LAG_WAIT;
        end
      end
      xle_pkg::S_LAG_WAIT: begin
        if (pipe_empty) begin
          state_d = xle_pkg::S_MUL_DEN;
        end
      end
      xle_pkg::S_MUL_DEN: begin
        if (mul_done) begin
          state_d = den_ok ? xle_pkg::S_MUL_SQ : xle_pkg::S_DECIDE;
        end
      end
      xle_pkg::S_MUL_SQ: begin
        if (mul_done) begin
          state_d = xle_pkg::S_DECIDE;
        end
      end
      xle_pkg::S_DECIDE: begin
        if (have_q && rank_a == rank_b && rank_a != 2'd1) begin
          state_d = xle_pkg::S_MUL_X;
        end else begin
          state_d = xle_pkg::S_NEXT;
        end
      end
      xle_pkg::S_MUL_X: begin
        if (mul_done) begin
          state_d = xle_pkg::S_MUL_Y;
        end
      end
      xle_pkg::S_MUL_Y: begin
        if (mul_done) begin
          state_d = xle_pkg::S_NEXT;
        end
      end
      xle_pkg::S_NEXT: begin
        state_d = last_lag ? xle_pkg::S_DONE : xle_pkg::S_LAG_START;
      end
      xle_pkg::S_DONE: begin
        state_d = xle_pkg::S_IDLE;
      end
      default: begin
        state_d = xle_pkg::S_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    busy     = 1'b1;
    done_o   = 1'b0;
    iss_v    = 1'b0;
    iss_dest = xle_pkg::DST_EIN;
    mul_load = 1'b0;
    mul_sel  = xle_pkg::MS_DEN;
    upd      = 1'b0;
    case (state_q)
      xle_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      xle_pkg::S_EIN: begin
        iss_v = 1'b1;
      end
      xle_pkg::S_LAG_RUN: begin
        iss_v    = 1'b1;
        iss_dest = phase_q ? xle_pkg::DST_E : xle_pkg::DST_P;
      end
      xle_pkg::S_LAG_WAIT: begin
        mul_load = pipe_empty;
      end
      xle_pkg::S_MUL_DEN: begin
        mul_load = mul_done && den_ok;
        mul_sel  = xle_pkg::MS_SQ;
      end
      xle_pkg::S_DECIDE: begin
        mul_sel = xle_pkg::MS_X;
        if (!have_q) begin
          // A first lag at correlation -1 or below does not count.
          upd = !(valid_q && p_q[PW-1] && sq_q >= den_q);
        end else if (rank_a != rank_b) begin
          upd = rank_a > rank_b;
        end else begin
          mul_load = rank_a != 2'd1;
        end
      end
      xle_pkg::S_MUL_X: begin
        mul_load = mul_done;
        mul_sel  = xle_pkg::MS_Y;
      end
      xle_pkg::S_MUL_Y: begin
        upd = mul_done && gt;
      end
      xle_pkg::S_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Operands of the shared shift-and-add unit.
  always_comb begin
    case (mul_sel)
      xle_pkg::MS_DEN: begin
        mul_a = (2*EW)'(ein_q[EW-1:0]);
        mul_b = e_q[EW-1:0];
      end
      xle_pkg::MS_SQ: begin
        mul_a = (2*EW)'(p_mag);
        mul_b = p_mag;
      end
      xle_pkg::MS_X: begin
        mul_a = sq_q;
        mul_b = be_q;
      end
      xle_pkg::MS_Y: begin
        mul_a = bsq_q;
        mul_b = e_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign m_sum = {1'b0, mr_q[MW-1:EW]} + (mr_q[0] ? {1'b0, ma_q} : '0);

  // Product operands, with samples beyond the fill count read as zero.
  always_comb begin
    case (s1_dest_q)
      xle_pkg::DST_EIN: begin
        op_a = s1_mref_q ? ref_rdata : '0;
        op_b = s1_mref_q ? ref_rdata : '0;
      end
      xle_pkg::DST_P: begin
        op_a = s1_mref_q ? ref_rdata : '0;
        op_b = s1_mrec_q ? rec_rdata : '0;
      end
      xle_pkg::DST_E: begin
        op_a = s1_mrec_q ? rec_rdata : '0;
        op_b = s1_mrec_q ? rec_rdata : '0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= xle_pkg::S_IDLE;
      wl_q       <= xle_pkg::WL_RESET;
      ml_q       <= xle_pkg::ML_RESET;
      cnt_q      <= '0;
      w_q        <= '0;
      nlag_q     <= '0;
      i_q        <= '0;
      phase_q    <= 1'b0;
      lag_q      <= '0;
      best_lag_q <= '0;
      have_q     <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      mcnt_q     <= '0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= iss_v;
      s2_v_q  <= s1_v_q;

      if (psel && penable && pwrite) begin
        if (paddr[2] == xle_pkg::REG_MAX_LAG) begin
          ml_q <= pwdata[xle_pkg::ML_W-1:0];
        end else begin
          wl_q <= pwdata[xle_pkg::WL_W-1:0];
        end
      end

      if (rec_we) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (state_q == xle_pkg::S_DONE) begin
        cnt_q <= '0;
      end

      case (state_q)
        xle_pkg::S_PREP: begin
          w_q        <= w_d;
          nlag_q     <= nlag_d;
          i_q        <= '0;
          lag_q      <= '0;
          best_lag_q <= '0;
          have_q     <= 1'b0;
        end
        xle_pkg::S_EIN: begin
          i_q <= i_q + IW'(1);
        end
        xle_pkg::S_LAG_START: begin
          i_q     <= '0;
          phase_q <= 1'b0;
        end
        xle_pkg::S_LAG_RUN: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            i_q <= i_q + IW'(1);
          end
        end
        xle_pkg::S_NEXT: begin
          lag_q <= lag_q + LW'(1);
        end
        default: begin
          phase_q <= phase_q;
        end
      endcase

      if (upd) begin
        best_lag_q <= lag_q;
        have_q     <= 1'b1;
      end

      if (mul_load) begin
        mcnt_q <= MCW'(EW);
      end else if (!mul_done) begin
        mcnt_q <= mcnt_q - MCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dest_q <= iss_dest;
    s1_mref_q <= CW'(i_q) < cnt_q;
    s1_mrec_q <= (CW'(i_q) + CW'(lag_q)) < cnt_q;
    s2_dest_q <= s1_dest_q;
    s2_prod_q <= op_a * op_b;

    if (state_q == xle_pkg::S_PREP) begin
      ein_q <= '0;
    end
    if (state_q == xle_pkg::S_LAG_START) begin
      p_q <= '0;
      e_q <= '0;
    end
    if (s2_v_q) begin
      case (s2_dest_q)
        xle_pkg::DST_EIN: ein_q <= ein_q + PW'(s2_prod_q);
        xle_pkg::DST_P:   p_q   <= p_q + PW'(s2_prod_q);
        xle_pkg::DST_E:   e_q   <= e_q + PW'(s2_prod_q);
        default:          ein_q <= ein_q;
      endcase
    end

    // Shift-and-add multiplier: one bit of the multiplier per cycle.
    if (mul_load) begin
      ma_q <= mul_a;
      mr_q <= {{(2*EW){1'b0}}, mul_b};
    end else if (!mul_done) begin
      mr_q <= {m_sum, mr_q[EW-1:1]};
    end

    if (state_q == xle_pkg::S_MUL_DEN && mul_done) begin
      den_q   <= mr_q[2*EW-1:0];
      valid_q <= den_ok;
      sq_q    <= '0;
    end
    if (state_q == xle_pkg::S_MUL_SQ && mul_done) begin
      sq_q <= mr_q[2*EW-1:0];
    end
    if (state_q == xle_pkg::S_MUL_X && mul_done) begin
      x_q <= mr_q;
    end

    if (upd) begin
      bp_q  <= p_eff;
      be_q  <= e_eff;
      bsq_q <= sq_q;
    end
  end

endmodule

`default_nettype wire
